### rtl/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants and types for the supersample box downscaler.
// ----------------------------------------------------------------------------
package sbd_pkg;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_FACTOR = 8;

	localparam int PIX_W      = 8;
	localparam int CFG_W      = 12;
	localparam int CFG_ADDR_W = 2;
	localparam int FACTOR_W   = 4;
	localparam int LWIDTH_W   = 12;

	localparam logic [CFG_ADDR_W-1:0] REG_FACTOR     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH = 2'd1;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd1;
	localparam logic [LWIDTH_W-1:0] LWIDTH_RESET = 12'd640;

	// per-pixel command from the controller to the datapath
	typedef struct packed {
		logic advance;
		logic accept;
		logic frame_start;
		logic store;
		logic overwrite;
		logic row_end;
	} cmd_t;

endpackage

### rtl/supersample_box_downscaler.sv
// ----------------------------------------------------------------------------
// supersample_box_downscaler
// Box-filter downscaler: each factor-by-factor block of an RGB stream
// becomes one pixel holding the floored channel averages.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel: one supersampled pixel per transfer in raster order,
//    frame_start marks the first pixel of a frame
//  - output channel: one pixel per finished block, row_end on the last
//    block of an output row
//  - throughput: one pixel per clock while in_stall is low; a block's
//    last pixel passes the line ram read, the sum update and the reciprocal
//    multiply into the output register before output valid
//  - per block column the channel sums live in a line ram of MAX_WIDTH
//    entries, read each accepted pixel, written once per block column and row
//  - a write of factor starts a recompute of the block column index, one
//    quotient bit a cycle, which holds in_stall high until it completes;
//    line_width writes take effect at once
//  - reset sets factor to 1, line_width to 640 and all counters to zero;
//    the line ram needs no clearing pass
//  - while out_stall holds back a waiting result the whole pipeline holds
//    and in_stall is raised
// ----------------------------------------------------------------------------
module supersample_box_downscaler #(
	parameter int MAX_WIDTH  = sbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = sbd_pkg::DEF_MAX_FACTOR
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [sbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sbd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sbd_pkg::PIX_W-1:0]     red_in,
	input  logic [sbd_pkg::PIX_W-1:0]     green_in,
	input  logic [sbd_pkg::PIX_W-1:0]     blue_in,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sbd_pkg::PIX_W-1:0]     red_out,
	output logic [sbd_pkg::PIX_W-1:0]     green_out,
	output logic [sbd_pkg::PIX_W-1:0]     blue_out,
	output logic                          row_end
);

	localparam int PW = $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_FACTOR + 1);

	sbd_pkg::cmd_t cmd;
	logic [PW-1:0] addr;
	logic [FW-1:0] factor_eff;

	sbd_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd),
		.addr       (addr),
		.factor_eff (factor_eff)
	);

	sbd_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.factor_eff(factor_eff),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.row_end   (row_end)
	);

endmodule

### rtl/sbd_ram.sv
// ----------------------------------------------------------------------------
// sbd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sbd_ctrl.sv
// ----------------------------------------------------------------------------
// sbd_ctrl
// Position counters, configuration registers, flow control and the
// block-column recompute after a factor write.
// ----------------------------------------------------------------------------
module sbd_ctrl #(
	parameter int MAX_WIDTH  = sbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = sbd_pkg::DEF_MAX_FACTOR,
	localparam int PW = $clog2(MAX_WIDTH),
	localparam int FW = $clog2(MAX_FACTOR + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [sbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [sbd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sbd_pkg::cmd_t                 cmd,
	output logic [PW-1:0]                 addr,
	output logic [FW-1:0]                 factor_eff
);

	localparam int CW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int XW = (PW + 1 > sbd_pkg::LWIDTH_W) ? PW + 1 : sbd_pkg::LWIDTH_W;
	localparam int FX = (FW > sbd_pkg::FACTOR_W) ? FW : sbd_pkg::FACTOR_W;
	localparam int NW = $clog2(PW + 1);

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DIV = 1'b1;

	logic [sbd_pkg::FACTOR_W-1:0] factor_q;
	logic [sbd_pkg::LWIDTH_W-1:0] line_width_q;
	logic                         state_q;
	logic [NW-1:0]                div_cnt_q;

	logic [PW-1:0] column_pos_q;
	logic [CW-1:0] col_in_block_q;
	logic [CW-1:0] row_in_block_q;
	logic [PW-1:0] bcol_q;
	logic [FW-1:0] bmod_q;

	logic e_s1, e_s2, e_s3;

	logic [FX-1:0] f_x;
	logic [FW-1:0] fe;
	logic [XW-1:0] lw_x;
	logic [XW-1:0] lwe;
	logic          advance;
	logic          accept;

	logic [PW-1:0] cp;
	logic [CW-1:0] cib;
	logic [CW-1:0] rib;
	logic [PW-1:0] bc;
	logic [FW-1:0] bm;
	logic          last_col;
	logic          last_in_block;
	logic          last_row;

	logic [FW:0]   div_t;
	logic          div_ge;

	always_comb begin
		f_x = FX'(factor_q);
		if (f_x == '0) begin
			fe = FW'(1);
		end else if (f_x > FX'(MAX_FACTOR)) begin
			fe = FW'(MAX_FACTOR);
		end else begin
			fe = FW'(f_x);
		end
		lw_x = XW'(line_width_q);
		if (lw_x == '0) begin
			lwe = XW'(1);
		end else if (lw_x > XW'(MAX_WIDTH)) begin
			lwe = XW'(MAX_WIDTH);
		end else begin
			lwe = lw_x;
		end
	end

	assign factor_eff = fe;
	assign advance    = !(e_s3 && out_stall);
	assign in_stall   = (state_q != ST_RUN) || !advance;
	assign accept     = in_valid && !in_stall;
	assign out_valid  = e_s3;

	always_comb begin
		cp  = frame_start ? '0 : column_pos_q;
		cib = frame_start ? '0 : col_in_block_q;
		rib = frame_start ? '0 : row_in_block_q;
		bc  = frame_start ? '0 : bcol_q;
		bm  = frame_start ? '0 : bmod_q;
		last_col      = XW'(cp) >= lwe - XW'(1);
		last_in_block = last_col || (FW'(cib) >= fe - FW'(1));
		last_row      = FW'(rib) >= fe - FW'(1);
	end

	assign addr             = bc;
	assign cmd.advance      = advance;
	assign cmd.accept       = accept;
	assign cmd.frame_start  = frame_start;
	assign cmd.store        = last_in_block;
	assign cmd.overwrite    = (rib == '0);
	assign cmd.row_end      = last_col;

	// one quotient bit a step, dividend shifted out of bcol_q
	assign div_t  = {bmod_q, bcol_q[PW-1]};
	assign div_ge = div_t >= (FW + 1)'(fe);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q       <= sbd_pkg::FACTOR_RESET;
			line_width_q   <= sbd_pkg::LWIDTH_RESET;
			state_q        <= ST_RUN;
			div_cnt_q      <= '0;
			column_pos_q   <= '0;
			col_in_block_q <= '0;
			row_in_block_q <= '0;
			bcol_q         <= '0;
			bmod_q         <= '0;
			e_s1           <= 1'b0;
			e_s2           <= 1'b0;
			e_s3           <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_addr)
					sbd_pkg::REG_FACTOR: begin
						factor_q <= cfg_data[sbd_pkg::FACTOR_W-1:0];
					end
					sbd_pkg::REG_LINE_WIDTH: begin
						line_width_q <= cfg_data[sbd_pkg::LWIDTH_W-1:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_RUN: begin
					if (cfg_write && cfg_addr == sbd_pkg::REG_FACTOR) begin
						state_q   <= ST_DIV;
						div_cnt_q <= NW'(PW);
						bcol_q    <= column_pos_q;
						bmod_q    <= '0;
					end else if (accept) begin
						if (last_in_block) begin
							col_in_block_q <= '0;
						end else begin
							col_in_block_q <= cib + CW'(1);
						end
						if (last_col) begin
							column_pos_q   <= '0;
							col_in_block_q <= '0;
							row_in_block_q <= last_row ? '0 : rib + CW'(1);
							bcol_q         <= '0;
							bmod_q         <= '0;
						end else begin
							column_pos_q   <= cp + PW'(1);
							row_in_block_q <= rib;
							if (bm + FW'(1) >= fe) begin
								bmod_q <= '0;
								bcol_q <= bc + PW'(1);
							end else begin
								bmod_q <= bm + FW'(1);
								bcol_q <= bc;
							end
						end
					end
				end
				ST_DIV: begin
					bcol_q <= {bcol_q[PW-2:0], div_ge};
					bmod_q <= div_ge ? FW'(div_t - (FW + 1)'(fe)) : FW'(div_t);
					div_cnt_q <= div_cnt_q - NW'(1);
					if (div_cnt_q == NW'(1)) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (advance) begin
				e_s1 <= accept && last_in_block && last_row;
				e_s2 <= e_s1;
				e_s3 <= e_s2;
			end
		end
	end

endmodule

### rtl/sbd_datapath.sv
// ----------------------------------------------------------------------------
// sbd_datapath
// Run sums, line accumulator read-modify-write and the divide by factor
// squared through a reciprocal multiply.
// ----------------------------------------------------------------------------
module sbd_datapath #(
	parameter int MAX_WIDTH  = sbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FACTOR = sbd_pkg::DEF_MAX_FACTOR,
	localparam int PW = $clog2(MAX_WIDTH),
	localparam int FW = $clog2(MAX_FACTOR + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sbd_pkg::cmd_t            cmd,
	input  logic [PW-1:0]            addr,
	input  logic [FW-1:0]            factor_eff,
	input  logic [sbd_pkg::PIX_W-1:0] red_in,
	input  logic [sbd_pkg::PIX_W-1:0] green_in,
	input  logic [sbd_pkg::PIX_W-1:0] blue_in,
	output logic [sbd_pkg::PIX_W-1:0] red_out,
	output logic [sbd_pkg::PIX_W-1:0] green_out,
	output logic [sbd_pkg::PIX_W-1:0] blue_out,
	output logic                     row_end
);

	localparam int CL = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int SW = sbd_pkg::PIX_W + 2 * CL;
	localparam int SH = SW + 2 * CL;
	localparam int RW = SH + 1;
	localparam int MW = SW + RW;

	typedef logic [SW-1:0] sum_t;

	sum_t run_q [3];
	sum_t run_s1 [3];
	sum_t fwd_q [3];
	sum_t wsum [3];
	sum_t sum_s2 [3];
	logic [MW-1:0] prod_s3 [3];
	sum_t pix [3];

	logic          st_s1;
	logic          ovw_s1;
	logic          fwd_s1;
	logic          re_s1;
	logic          re_s2;
	logic [PW-1:0] addr_s1;
	logic          fwd_hit;

	logic [3*SW-1:0] rdata;
	logic [3*SW-1:0] wdata;
	logic [RW-1:0]   rtab [1:MAX_FACTOR];
	logic [RW-1:0]   recip;

	for (genvar g = 1; g <= MAX_FACTOR; g++) begin : g_recip
		// ceiling reciprocal of g squared, exact for every sum below 2**SW
		localparam longint unsigned RV =
			((64'd1 << SH) + longint'(g * g) - 64'd1) / longint'(g * g);
		assign rtab[g] = RW'(RV);
	end

	assign recip = rtab[factor_eff];

	assign pix[0] = SW'(red_in);
	assign pix[1] = SW'(green_in);
	assign pix[2] = SW'(blue_in);

	assign fwd_hit = st_s1 && (addr_s1 == addr);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (ovw_s1) begin
				wsum[c] = run_s1[c];
			end else if (fwd_s1) begin
				wsum[c] = fwd_q[c] + run_s1[c];
			end else begin
				wsum[c] = rdata[c*SW +: SW] + run_s1[c];
			end
			wdata[c*SW +: SW] = wsum[c];
		end
	end

	sbd_ram #(
		.WIDTH(3 * SW),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (cmd.advance && st_s1),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (cmd.accept),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				run_q[c] <= '0;
			end
		end else if (cmd.advance) begin
			st_s1 <= cmd.accept && cmd.store;
			if (cmd.accept) begin
				for (int c = 0; c < 3; c++) begin
					run_q[c] <= cmd.store ? '0
						: (cmd.frame_start ? '0 : run_q[c]) + pix[c];
				end
			end
		end
	end

	// payload stages, held while the output is stalled
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			if (cmd.accept) begin
				addr_s1 <= addr;
				ovw_s1  <= cmd.overwrite;
				re_s1   <= cmd.row_end;
				fwd_s1  <= fwd_hit;
				for (int c = 0; c < 3; c++) begin
					run_s1[c] <= (cmd.frame_start ? '0 : run_q[c]) + pix[c];
					// same entry written at this edge, the ram gives old data
					fwd_q[c]  <= wsum[c];
				end
			end
			re_s2   <= re_s1;
			row_end <= re_s2;
			for (int c = 0; c < 3; c++) begin
				sum_s2[c]  <= wsum[c];
				prod_s3[c] <= MW'(sum_s2[c]) * MW'(recip);
			end
		end
	end

	assign red_out   = prod_s3[0][SH +: sbd_pkg::PIX_W];
	assign green_out = prod_s3[1][SH +: sbd_pkg::PIX_W];
	assign blue_out  = prod_s3[2][SH +: sbd_pkg::PIX_W];

endmodule
